// ----- rtl/srtk_pkg.sv -----
// ----------------------------------------------------------------------------
// srtk_pkg
// Shared types and constants for the sorted top-K insert table.
// ----------------------------------------------------------------------------
`default_nettype none

package srtk_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned TAG_W    = 24;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TAG_PORT_CHARS = TAG_W / CHAR_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic compare;  // register per-entry compare flags
    logic execute;  // update table, register the result
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/srtk_ctrl.sv -----
// ----------------------------------------------------------------------------
// srtk_ctrl
// Sequencer: accept an item, compare, execute, then hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srtk_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output srtk_pkg::cmd_t     cmd_o
);
  import srtk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMP;
      end
      ST_CMP:  state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.compare = (state_q == ST_CMP);
  assign cmd_o.execute = (state_q == ST_EXEC);

endmodule

`default_nettype wire

// ----- rtl/srtk_datapath.sv -----
// ----------------------------------------------------------------------------
// srtk_datapath
// Entry cells with parallel compare and one-step shift, plus result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srtk_datapath #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned TAG_CHARS     = 3
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire srtk_pkg::cmd_t                 cmd_i,
  input  wire logic [srtk_pkg::OPCODE_W-1:0]  opcode_i,
  input  wire logic [srtk_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic signed [srtk_pkg::SCORE_W-1:0] score_in_i,
  input  wire logic [srtk_pkg::TAG_W-1:0]     tag_in_i,
  output logic                                placed_o,
  output logic [srtk_pkg::POS_W-1:0]          position_o,
  output logic                                qualifies_o,
  output logic signed [srtk_pkg::SCORE_W-1:0] score_out_o,
  output logic [srtk_pkg::TAG_W-1:0]          tag_out_o
);
  import srtk_pkg::*;

  // TAG_CHARS tag characters are kept, but no more than the port carries
  localparam int unsigned TagChars  = (TAG_CHARS < TAG_PORT_CHARS) ? TAG_CHARS
                                                                   : TAG_PORT_CHARS;
  localparam int unsigned TagStoreW = TagChars * CHAR_W;

  logic signed [SCORE_W-1:0]   cell_score_q [TABLE_ENTRIES];
  logic [TagStoreW-1:0]        cell_tag_q   [TABLE_ENTRIES];

  op_e                         op_q;
  logic [SLOT_W-1:0]           slot_q;
  logic signed [SCORE_W-1:0]   score_q;
  logic [TagStoreW-1:0]        tag_q;
  logic [TABLE_ENTRIES-1:0]    le_q;
  logic                        gt_last_q;

  logic [TABLE_ENTRIES-1:0]    hit_before;
  logic [TABLE_ENTRIES-1:0]    first_hit;
  logic [TABLE_ENTRIES-1:0]    slot_match;
  logic [POS_W-1:0]            hit_pos;
  logic signed [SCORE_W-1:0]   rd_score;
  logic [TagStoreW-1:0]        rd_tag;

  logic                        placed_q;
  logic [POS_W-1:0]            position_q;
  logic                        qualifies_q;
  logic signed [SCORE_W-1:0]   score_out_q;
  logic [TAG_W-1:0]            tag_out_q;

  // Latch the item, then the compare flags against every cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(opcode_i);
      slot_q  <= slot_i;
      score_q <= score_in_i;
      tag_q   <= tag_in_i[TagStoreW-1:0];
    end
    if (cmd_i.compare) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        le_q[i] <= (cell_score_q[i] <= score_q);
      end
      gt_last_q <= (score_q > cell_score_q[TABLE_ENTRIES-1]);
    end
  end

  // First matching cell, its index and the slot decode
  always_comb begin
    hit_pos  = '0;
    rd_score = '0;
    rd_tag   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_before[i] = |(le_q & ((TABLE_ENTRIES)'(1) << i) - (TABLE_ENTRIES)'(1));
      first_hit[i]  = le_q[i] && !hit_before[i];
      slot_match[i] = (int'(slot_q) == i);
      if (first_hit[i]) hit_pos = hit_pos | POS_W'(i);
      if (slot_match[i]) begin
        rd_score = rd_score | cell_score_q[i];
        rd_tag   = rd_tag | cell_tag_q[i];
      end
    end
  end

  // Entry cells: load one, or shift below the landing point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cell_score_q[i] <= '0;
        cell_tag_q[i]   <= '0;
      end
    end else if (cmd_i.execute) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (op_q == OP_LOAD && slot_match[i]) begin
          cell_score_q[i] <= score_q;
          cell_tag_q[i]   <= tag_q;
        end else if (op_q == OP_INSERT && first_hit[i]) begin
          cell_score_q[i] <= score_q;
          cell_tag_q[i]   <= tag_q;
        end else if (op_q == OP_INSERT && hit_before[i] && i > 0) begin
          cell_score_q[i] <= cell_score_q[(i > 0) ? i - 1 : 0];
          cell_tag_q[i]   <= cell_tag_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Result register: fields unused by the operation read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      placed_q    <= (op_q == OP_INSERT) && (|le_q);
      position_q  <= (op_q == OP_INSERT) ? hit_pos : '0;
      qualifies_q <= (op_q == OP_QUERY) && gt_last_q;
      score_out_q <= (op_q == OP_READ) ? rd_score : '0;
      tag_out_q   <= (op_q == OP_READ) ? TAG_W'(rd_tag) : '0;
    end
  end

  assign placed_o    = placed_q;
  assign position_o  = position_q;
  assign qualifies_o = qualifies_q;
  assign score_out_o = score_out_q;
  assign tag_out_o   = tag_out_q;

endmodule

`default_nettype wire

// ----- rtl/sorted_top_k_insert_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_top_k_insert_table_unit
// Top-K table of (score, tag) entries kept in descending score order.
// ----------------------------------------------------------------------------
// Each item carries one operation: load an entry at a slot, insert a score
// ahead of the first entry whose score is less than or equal to it (the
// last entry drops out), read an entry at a slot, or query whether a score
// beats the last entry. Every item yields exactly one result item. On
// acceptance the item is latched, then the parallel compare of all
// entries is registered, then the entries shift and the result is
// registered. The result then waits for out_ready_i, and the next item
// can be accepted at the edge after the result is taken, so no new item
// is accepted before the last result is taken. After reset all entries
// are zero. Slots beyond the table are ignored on load and read as zero.
`default_nettype none

module sorted_top_k_insert_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned TAG_CHARS     = 3
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [srtk_pkg::OPCODE_W-1:0]        opcode_i,
  input  wire logic [srtk_pkg::SLOT_W-1:0]          slot_i,
  input  wire logic signed [srtk_pkg::SCORE_W-1:0]  score_in_i,
  input  wire logic [srtk_pkg::TAG_W-1:0]           tag_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      placed_o,
  output logic [srtk_pkg::POS_W-1:0]                position_o,
  output logic                                      qualifies_o,
  output logic signed [srtk_pkg::SCORE_W-1:0]       score_out_o,
  output logic [srtk_pkg::TAG_W-1:0]                tag_out_o
);
  import srtk_pkg::*;

  cmd_t cmd;

  srtk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  srtk_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TAG_CHARS     (TAG_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (opcode_i),
    .slot_i      (slot_i),
    .score_in_i  (score_in_i),
    .tag_in_i    (tag_in_i),
    .placed_o    (placed_o),
    .position_o  (position_o),
    .qualifies_o (qualifies_o),
    .score_out_o (score_out_o),
    .tag_out_o   (tag_out_o)
  );

endmodule

`default_nettype wire

// ----- tb/sorted_top_k_insert_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_top_k_insert_table_unit_tb
// Self-checking testbench for the sorted top-K insert table.
// ----------------------------------------------------------------------------
// Drives load, insert, read and query items through the valid/ready input
// channel, keeps a shadow copy of the eight-entry table to predict every
// result, and compares each result item field by field in arrival order.
// A directed part covers the score extremes, ties, rejected inserts and the
// query threshold; random phases follow with the sender and receiver idling
// at different rates, then with no idling at all.
module sorted_top_k_insert_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srtk_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned TAG_CHARS     = 3;
  localparam logic [TAG_W-1:0] TAG_KEEP = TAG_W'((64'd1 << (CHAR_W * TAG_CHARS)) - 1);
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      placed;
    logic [POS_W-1:0]          position;
    logic                      qualifies;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } table_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [OPCODE_W-1:0]       opcode_i = OP_LOAD;
  logic [SLOT_W-1:0]         slot_i = '0;
  logic signed [SCORE_W-1:0] score_in_i = '0;
  logic [TAG_W-1:0]          tag_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      placed_o;
  logic [POS_W-1:0]          position_o;
  logic                      qualifies_o;
  logic signed [SCORE_W-1:0] score_out_o;
  logic [TAG_W-1:0]          tag_out_o;

  // Shadow table and pending results
  logic signed [SCORE_W-1:0] shadow_score [TABLE_ENTRIES];
  logic [TAG_W-1:0]          shadow_tag   [TABLE_ENTRIES];
  table_result_t             expected_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;

  sorted_top_k_insert_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .TAG_CHARS    (TAG_CHARS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .slot_i     (slot_i),
    .score_in_i (score_in_i),
    .tag_in_i   (tag_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .placed_o   (placed_o),
    .position_o (position_o),
    .qualifies_o(qualifies_o),
    .score_out_o(score_out_o),
    .tag_out_o  (tag_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_score[i] = '0;
      shadow_tag[i]   = '0;
    end
  end

  // Apply one operation to the shadow table and return its result item.
  function automatic table_result_t apply_table_op(op_e op, logic [SLOT_W-1:0] slot,
                                                   logic signed [SCORE_W-1:0] score,
                                                   logic [TAG_W-1:0] tag);
    table_result_t res;
    logic [TAG_W-1:0] kept_tag;
    bit hit;
    res = '0;
    hit = 1'b0;
    kept_tag = tag & TAG_KEEP;
    case (op)
      OP_LOAD: begin
        if (slot < TABLE_ENTRIES) begin
          shadow_score[slot] = score;
          shadow_tag[slot]   = kept_tag;
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!hit && shadow_score[i] <= score) begin
            for (int j = TABLE_ENTRIES - 1; j > i; j--) begin
              shadow_score[j] = shadow_score[j-1];
              shadow_tag[j]   = shadow_tag[j-1];
            end
            shadow_score[i] = score;
            shadow_tag[i]   = kept_tag;
            res.placed      = 1'b1;
            res.position    = POS_W'(i);
            hit             = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (slot < TABLE_ENTRIES) begin
          res.score = shadow_score[slot];
          res.tag   = shadow_tag[slot];
        end
      end
      default: begin
        res.qualifies = (score > shadow_score[TABLE_ENTRIES-1]);
      end
    endcase
    return res;
  endfunction

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on each accepted input item, check each accepted result item.
  always @(posedge clk_i) begin
    table_result_t exp_res;
    table_result_t got_res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(),
                                apply_table_op(op_e'(opcode_i), slot_i, score_in_i,
                                               tag_in_i));
      end
      if (out_valid_o && out_ready_i) begin
        got_res = '{placed_o, position_o, qualifies_o, score_out_o, tag_out_o};
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Unexpected result item: placed=%0b pos=%0d qual=%0b score=%0d tag=%h",
                     placed_o, position_o, qualifies_o, score_out_o, tag_out_o);
          end
        end else begin
          exp_res = expected_results.pop_front();
          if (got_res.placed !== exp_res.placed || got_res.position !== exp_res.position ||
              got_res.qualifies !== exp_res.qualifies || got_res.score !== exp_res.score ||
              got_res.tag !== exp_res.tag) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Mismatch at %0t: expected placed=%0b pos=%0d qual=%0b score=%0d tag=%h",
                       $realtime, exp_res.placed, exp_res.position, exp_res.qualifies,
                       exp_res.score, exp_res.tag);
              $display("                 actual placed=%0b pos=%0d qual=%0b score=%0d tag=%h",
                       got_res.placed, got_res.position, got_res.qualifies,
                       got_res.score, got_res.tag);
            end
          end
        end
      end
    end
  end

  // Send one item; hold valid and payload until accepted.
  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot,
                           logic signed [SCORE_W-1:0] score, logic [TAG_W-1:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    slot_i     <= slot;
    score_in_i <= score;
    tag_in_i   <= tag;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic test_load_read_extremes();
    send_item(OP_LOAD, 3'd0, SCORE_MAX, 24'hFFFFFF);
    send_item(OP_LOAD, 3'd7, SCORE_MIN, 24'h000000);
    send_item(OP_READ, 3'd0, '0, '0);
    send_item(OP_READ, 3'd7, '0, '0);
    send_item(OP_READ, 3'd3, SCORE_MAX, 24'hFFFFFF);
  endtask

  task automatic test_insert_ties_and_rejects();
    // tie with a stored zero: the new entry goes in front
    send_item(OP_INSERT, 3'd5, 32'sd0, 24'h414243);
    // every stored score above it: not placed
    send_item(OP_INSERT, 3'd0, -32'sd5, 24'h585958);
    send_item(OP_INSERT, 3'd0, SCORE_MAX, 24'hAAAAAA);
    send_item(OP_INSERT, 3'd7, 32'sd7, 24'h555555);
  endtask

  task automatic test_query_threshold();
    send_item(OP_QUERY, 3'd0, -32'sd1, '0);
    send_item(OP_QUERY, 3'd0, 32'sd0, '0);
    send_item(OP_QUERY, 3'd0, 32'sd1, '0);
    send_item(OP_QUERY, 3'd0, SCORE_MIN, '0);
    send_item(OP_LOAD,  3'd7, 32'sd100, 24'h010203);
    send_item(OP_QUERY, 3'd0, 32'sd100, '0);
    send_item(OP_QUERY, 3'd0, 32'sd101, '0);
  endtask

  task automatic test_read_all_slots();
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      send_item(OP_READ, SLOT_W'(s), '0, '0);
    end
  endtask

  // Half the scores are small or copied from the table, so ties and mid-table inserts happen.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0, 1, 2: return SCORE_W'($signed($urandom_range(0, 40)) - 20);
      3:       return SCORE_W'($urandom_range(0, 3) == 0 ? SCORE_MIN :
                               $urandom_range(0, 2) == 0 ? SCORE_MAX : -1);
      4, 5:    return shadow_score[$urandom_range(0, TABLE_ENTRIES - 1)];
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_mix(int send_pct, int recv_pct, int count);
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(OP_INSERT, SLOT_W'($urandom), pick_score(), TAG_W'($urandom));
      end else if (pick < 60) begin
        send_item(OP_QUERY, SLOT_W'($urandom), pick_score(), TAG_W'($urandom));
      end else if (pick < 85) begin
        send_item(OP_READ, SLOT_W'($urandom), $urandom, TAG_W'($urandom));
      end else begin
        send_item(OP_LOAD, SLOT_W'($urandom), pick_score(), TAG_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct  = 24;
    recv_stall_pct = 66;
    test_load_read_extremes();
    test_insert_ties_and_rejects();
    test_query_threshold();
    test_read_all_slots();
    test_random_mix(24, 66, 370);
    test_random_mix(66, 24, 370);
    test_random_mix(0, 0, 370);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
